/* sv/bmsd_pkg.sv */
// Package for the button matrix scanner: sizes, request/event structs and
// the per-lane event type. No dependencies; every other file imports it.
`default_nettype none

package bmsd_pkg;

	localparam int ROW_COUNT   = 8;
	localparam int COL_COUNT   = 4;
	localparam int SAMPLE_BITS = 10;
	localparam int ROW_W       = 3;
	localparam int COL_W       = 2;
	localparam int ID_W        = 5;
	localparam int TIMER_W     = 8;
	localparam int HOLD_W      = 8;
	localparam int CFG_W       = SAMPLE_BITS;
	localparam int CFG_IDX_W   = 1;

	// Reset values of the configuration registers
	localparam logic [SAMPLE_BITS-1:0] PRESS_LEVEL_RST = SAMPLE_BITS'(200);
	localparam logic [HOLD_W-1:0]      HOLD_RST        = HOLD_W'(10);

	// Request kinds
	localparam logic REQ_SCAN = 1'b0;
	localparam logic REQ_TICK = 1'b1;

	// Event kinds
	localparam logic EV_PRESS   = 1'b0;
	localparam logic EV_RELEASE = 1'b1;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_PRESS_LEVEL = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_HOLD = 1'b1;

	typedef struct packed {
		logic                   req_type;
		logic [ROW_W-1:0]       row_index;
		logic [SAMPLE_BITS-1:0] sample_col0;
		logic [SAMPLE_BITS-1:0] sample_col1;
		logic [SAMPLE_BITS-1:0] sample_col2;
		logic [SAMPLE_BITS-1:0] sample_col3;
	} in_req_t;

	typedef struct packed {
		logic            event_kind;
		logic [ID_W-1:0] button_id;
		logic            last_event;
	} out_evt_t;

	// What one column lane found for the scanned row
	typedef struct packed {
		logic hit;
		logic kind;
	} lane_ev_t;

endpackage

`default_nettype wire

/* sv/bmsd_lane.sv */
// One column lane: holds off timers and report flags for the buttons of its
// column and decides the press/release event for the scanned row. Uses bmsd_pkg.
`default_nettype none

module bmsd_lane
	import bmsd_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   scan_en,
	input  wire logic                   tick_en,
	input  wire logic [ROW_W-1:0]       row,
	input  wire logic [SAMPLE_BITS-1:0] sample,
	input  wire logic [SAMPLE_BITS-1:0] press_level,
	input  wire logic [HOLD_W-1:0]      release_hold,
	output lane_ev_t                    ev
);

	logic [TIMER_W-1:0]   timer_q [ROW_COUNT];
	logic [ROW_COUNT-1:0] counting_q;
	logic [ROW_COUNT-1:0] press_rep_q;
	logic [ROW_COUNT-1:0] rel_rep_q;

	logic               pressed;
	logic [TIMER_W-1:0] timer_cur;
	logic               count_keep;
	logic               release_due;
	logic               press_ev;
	logic               rel_ev;

	// Evaluate the scanned button
	always_comb begin
		pressed     = sample > press_level;
		count_keep  = counting_q[row] && !pressed;
		timer_cur   = count_keep ? timer_q[row] : '0;
		release_due = timer_cur > release_hold;
		press_ev    = pressed && !press_rep_q[row];
		rel_ev      = release_due && !rel_rep_q[row];
		ev.hit      = scan_en && (press_ev || rel_ev);
		ev.kind     = press_ev ? EV_PRESS : EV_RELEASE;
	end

	// Update state on a scan or advance all timers on a tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ROW_COUNT; i++) begin
				timer_q[i] <= '0;
			end
			counting_q  <= '0;
			press_rep_q <= '0;
			rel_rep_q   <= '1;
		end else if (tick_en) begin
			for (int i = 0; i < ROW_COUNT; i++) begin
				if (timer_q[i] != '1) begin
					timer_q[i] <= timer_q[i] + TIMER_W'(1);
				end
			end
		end else if (scan_en) begin
			timer_q[row]    <= timer_cur;
			counting_q[row] <= !pressed && !release_due;
			if (press_ev) begin
				press_rep_q[row] <= 1'b1;
				rel_rep_q[row]   <= 1'b0;
			end else if (rel_ev) begin
				press_rep_q[row] <= 1'b0;
				rel_rep_q[row]   <= 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

/* sv/bmsd_merge.sv */
// Merge stage: captures the lane events of one request, hands them out one per cycle
// unless stalled, lowest column first, through an output register. Uses bmsd_pkg.
`default_nettype none

module bmsd_merge
	import bmsd_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             load_en,
	input  wire logic [ROW_W-1:0] row,
	input  wire lane_ev_t         ev [COL_COUNT],
	output logic                  take_ok,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output out_evt_t              out_data
);

	logic [COL_COUNT-1:0] pend_s1;
	logic [COL_COUNT-1:0] kind_s1;
	logic [ROW_W-1:0]     row_s1;
	logic                 out_valid_q;
	out_evt_t             out_q;

	logic [COL_COUNT-1:0] hits;
	logic                 pend_any;
	logic                 pop;
	logic [COL_W-1:0]     sel;
	logic [COL_COUNT-1:0] pend_rest;

	// Gather the lane hits, column c on bit c
	always_comb begin
		for (int c = 0; c < COL_COUNT; c++) begin
			hits[c] = ev[c].hit;
		end
	end

	// Pick the lowest pending column
	always_comb begin
		sel = '0;
		for (int c = COL_COUNT - 1; c >= 0; c--) begin
			if (pend_s1[c]) begin
				sel = COL_W'(c);
			end
		end
		pend_any       = |pend_s1;
		pend_rest      = pend_s1;
		pend_rest[sel] = 1'b0;
		pop            = pend_any && (!out_valid_q || out_ready);
		take_ok        = !pend_any || (pop && (pend_rest == '0));
	end

	// Hold pending lane events of the current request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_s1 <= '0;
		end else if (load_en) begin
			pend_s1 <= hits;
		end else if (pop) begin
			pend_s1 <= pend_rest;
		end
	end

	always_ff @(posedge clk) begin
		if (load_en) begin
			for (int c = 0; c < COL_COUNT; c++) begin
				kind_s1[c] <= ev[c].kind;
			end
			row_s1 <= row;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_q.event_kind <= kind_s1[sel];
			out_q.button_id  <= ID_W'(ID_W'(sel) * ID_W'(ROW_COUNT)) + ID_W'(row_s1);
			out_q.last_event <= pend_rest == '0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

`default_nettype wire

/* sv/button_matrix_scan_debounce_core.sv */
// Top level of the button matrix scanner with release debounce: config
// registers, four column lanes and the event merge stage. Uses bmsd_pkg,
// bmsd_lane and bmsd_merge.
//
//   channel  handshake            payload
//   in       in_valid/in_ready    in_data  (in_req_t: scan or tick request)
//   out      out_valid/out_ready  out_data (out_evt_t: one event)
//   cfg      cfg_we               cfg_addr, cfg_wdata (no wait, no read-back)
//
// A request updates lane state at the edge that accepts it; its events are
// captured in the merge stage's pending register and then enter the output
// register one per cycle while the output is not stalled (up to 4 events for
// a scan; a tick or quiet scan gives none).
// in_ready is high only while no event is pending or the last pending one
// moves into the output register this cycle, so a stalled output holds input.
// Reset clears all timers and flags; release flags come up set.
`default_nettype none

module button_matrix_scan_debounce_core
	import bmsd_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire in_req_t              in_data,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output out_evt_t                  out_data,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_addr,
	input  wire logic [CFG_W-1:0]     cfg_wdata
);

	logic [SAMPLE_BITS-1:0] press_level_q;
	logic [HOLD_W-1:0]      hold_q;

	logic                   accept;
	logic                   scan_en;
	logic                   tick_en;
	logic [SAMPLE_BITS-1:0] samples [COL_COUNT];
	lane_ev_t               lane_ev [COL_COUNT];

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			press_level_q <= PRESS_LEVEL_RST;
			hold_q        <= HOLD_RST;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				CFG_PRESS_LEVEL:  press_level_q <= cfg_wdata;
				CFG_RELEASE_HOLD: hold_q        <= cfg_wdata[HOLD_W-1:0];
				default: ;
			endcase
		end
	end

	// Decode the accepted request
	always_comb begin
		accept     = in_valid && in_ready;
		tick_en    = accept && (in_data.req_type == REQ_TICK);
		scan_en    = accept && (in_data.req_type == REQ_SCAN)
			&& ({1'b0, in_data.row_index} < (ROW_W + 1)'(ROW_COUNT));
		samples[0] = in_data.sample_col0;
		samples[1] = in_data.sample_col1;
		samples[2] = in_data.sample_col2;
		samples[3] = in_data.sample_col3;
	end

	// Column lanes
	for (genvar c = 0; c < COL_COUNT; c++) begin : g_lane
		bmsd_lane u_lane (
			.clk          (clk),
			.arst_n       (arst_n),
			.scan_en      (scan_en),
			.tick_en      (tick_en),
			.row          (in_data.row_index),
			.sample       (samples[c]),
			.press_level  (press_level_q),
			.release_hold (hold_q),
			.ev           (lane_ev[c])
		);
	end

	// Serialize lane events
	bmsd_merge u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.load_en   (accept),
		.row       (in_data.row_index),
		.ev        (lane_ev),
		.take_ok   (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

`default_nettype wire

/* tb/bmsd_event_checker.sv */
// Event checker for the button matrix scanner: watches the request, event and
// config ports, predicts press/release events and compares them in order.
// Depends on bmsd_pkg for the request/event structs, sizes and codes.
`timescale 1ns / 1ps

module bmsd_event_checker
	import bmsd_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_ready,
	input  in_req_t              in_data,
	input  logic                 out_valid,
	input  logic                 out_ready,
	input  out_evt_t             out_data,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_addr,
	input  logic [CFG_W-1:0]     cfg_wdata,
	output int                   pending_events,
	output int                   fail_count
);

	localparam int BTN_COUNT  = ROW_COUNT * COL_COUNT;
	localparam int PRINT_CAP  = 100;

	// Shadow copy of the registers and per-button debounce state
	logic [SAMPLE_BITS-1:0] level_reg;
	logic [HOLD_W-1:0]      hold_reg;
	logic [TIMER_W-1:0]     off_timer [BTN_COUNT];
	bit                     off_counting [BTN_COUNT];
	bit                     press_seen [BTN_COUNT];
	bit                     release_seen [BTN_COUNT];

	out_evt_t predicted_events [$];
	int       mismatch_total;

	task automatic report_mismatch(input string what);
		if (mismatch_total < PRINT_CAP)
			$display("%0t checker: %s", $realtime, what);
		mismatch_total++;
	endtask

	// Run one request through the debounce rules and queue the events it causes
	task automatic predict_button_events(input in_req_t req);
		logic [SAMPLE_BITS-1:0] reading [COL_COUNT];
		out_evt_t               batch [$];
		out_evt_t               ev;
		int                     btn;
		bit                     down;
		if (req.req_type == REQ_TICK) begin
			// advance every off timer, holding at full scale
			for (int b = 0; b < BTN_COUNT; b++)
				if (off_timer[b] != '1)
					off_timer[b] = off_timer[b] + 1'b1;
			return;
		end
		// drop rows past the grid
		if (int'(req.row_index) >= ROW_COUNT)
			return;
		reading[0] = req.sample_col0;
		reading[1] = req.sample_col1;
		reading[2] = req.sample_col2;
		reading[3] = req.sample_col3;
		for (int c = 0; c < COL_COUNT; c++) begin
			btn  = c * ROW_COUNT + int'(req.row_index);
			down = reading[c] > level_reg;
			if (down) begin
				off_counting[btn] = 1'b0;
				if (!press_seen[btn]) begin
					press_seen[btn]   = 1'b1;
					release_seen[btn] = 1'b0;
					ev.event_kind = EV_PRESS;
					ev.button_id  = ID_W'(btn);
					ev.last_event = 1'b0;
					batch.push_back(ev);
				end
			end
			if (!off_counting[btn])
				off_timer[btn] = '0;
			if (!down)
				off_counting[btn] = 1'b1;
			if (off_timer[btn] > hold_reg) begin
				off_counting[btn] = 1'b0;
				if (!release_seen[btn]) begin
					release_seen[btn] = 1'b1;
					press_seen[btn]   = 1'b0;
					ev.event_kind = EV_RELEASE;
					ev.button_id  = ID_W'(btn);
					ev.last_event = 1'b0;
					batch.push_back(ev);
				end
			end
		end
		// mark the final event of this request
		if (batch.size() > 0) begin
			ev = batch[batch.size() - 1];
			ev.last_event = 1'b1;
			batch[batch.size() - 1] = ev;
		end
		foreach (batch[i])
			predicted_events.push_back(batch[i]);
	endtask

	// Compare one event against the oldest prediction, field by field
	task automatic check_event(input out_evt_t got);
		out_evt_t want;
		if (predicted_events.size() == 0) begin
			report_mismatch($sformatf("unexpected event kind %0d button %0d last %0d",
				got.event_kind, got.button_id, got.last_event));
			return;
		end
		want = predicted_events.pop_front();
		if (got.event_kind !== want.event_kind)
			report_mismatch($sformatf("button %0d: kind %0d, want %0d",
				want.button_id, got.event_kind, want.event_kind));
		if (got.button_id !== want.button_id)
			report_mismatch($sformatf("button id %0d, want %0d",
				got.button_id, want.button_id));
		if (got.last_event !== want.last_event)
			report_mismatch($sformatf("button %0d: last mark %0d, want %0d",
				want.button_id, got.last_event, want.last_event));
	endtask

	// Track registers, requests and events on every edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_reg = PRESS_LEVEL_RST;
			hold_reg  = HOLD_RST;
			for (int b = 0; b < BTN_COUNT; b++) begin
				off_timer[b]    = '0;
				off_counting[b] = 1'b0;
				press_seen[b]   = 1'b0;
				release_seen[b] = 1'b1;
			end
			predicted_events.delete();
			mismatch_total = 0;
			pending_events <= 0;
			fail_count     <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_addr)
				CFG_PRESS_LEVEL: level_reg = cfg_wdata[SAMPLE_BITS-1:0];
				CFG_RELEASE_HOLD: hold_reg = cfg_wdata[HOLD_W-1:0];
				default: ;
				endcase
			end
			if (out_valid && out_ready)
				check_event(out_data);
			if (in_valid && in_ready)
				predict_button_events(in_data);
			pending_events <= predicted_events.size();
			fail_count     <= mismatch_total;
		end
	end

endmodule

/* tb/button_matrix_scan_debounce_core_test.sv */
// Testbench top for the button matrix scanner: clock, reset, request and
// config stimulus, event-port stalls and the verdict. Uses bmsd_pkg, the
// core and bmsd_event_checker.
`timescale 1ns / 1ps

module button_matrix_scan_debounce_core_test;
	import bmsd_pkg::*;

	localparam int RANDOM_REQUESTS = 200;
	localparam int HOLD_OFF_CYCLES = 400;
	localparam int SETTLE_CYCLES   = 6;
	localparam int LIMIT_CYCLES    = 300000;

	typedef enum int {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_TOGGLE} rx_mode_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	in_req_t              in_data;
	logic                 out_valid;
	logic                 out_ready;
	out_evt_t             out_data;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_addr;
	logic [CFG_W-1:0]     cfg_wdata;

	int pending_events;
	int mismatch_count;
	int hold_off_asked;
	int burst_left;
	int requests_sent;
	int cur_level;
	int cycle_count;
	bit held_down [ROW_COUNT * COL_COUNT];

	always #5 clk = ~clk;

	button_matrix_scan_debounce_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata)
	);

	bmsd_event_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.in_data        (in_data),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.out_data       (out_data),
		.cfg_we         (cfg_we),
		.cfg_addr       (cfg_addr),
		.cfg_wdata      (cfg_wdata),
		.pending_events (pending_events),
		.fail_count     (mismatch_count)
	);

	// Offer one request, hold it until taken, then maybe idle between bursts
	task automatic send_request(input in_req_t req);
		in_valid <= 1'b1;
		in_data  <= req;
		do @(posedge clk); while (!in_ready);
		requests_sent++;
		if (burst_left > 0)
			burst_left--;
		else begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
				: $urandom_range(0, 8);
		end
	endtask

	// Stop offering and wait for every predicted event to come out
	task automatic drain_events();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_events != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
		cfg_we    <= 1'b1;
		cfg_addr  <= idx;
		cfg_wdata <= CFG_W'(value);
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic apply_setting(input int level, input int hold);
		drain_events();
		write_reg(CFG_PRESS_LEVEL, level);
		write_reg(CFG_RELEASE_HOLD, hold);
		cur_level = level;
	endtask

	function automatic in_req_t scan_of(input int row, input int s0, input int s1,
		input int s2, input int s3);
		in_req_t req;
		req.req_type    = REQ_SCAN;
		req.row_index   = ROW_W'(row);
		req.sample_col0 = SAMPLE_BITS'(s0);
		req.sample_col1 = SAMPLE_BITS'(s1);
		req.sample_col2 = SAMPLE_BITS'(s2);
		req.sample_col3 = SAMPLE_BITS'(s3);
		return req;
	endfunction

	// Tick with random row and sample fields; the block must ignore them
	function automatic in_req_t tick_request();
		in_req_t req;
		req = scan_of($urandom, $urandom, $urandom, $urandom, $urandom);
		req.req_type = REQ_TICK;
		return req;
	endfunction

	// Reading of a held or open key, hitting the threshold edges now and then
	function automatic logic [SAMPLE_BITS-1:0] analog_reading(input bit down);
		int pick;
		pick = $urandom_range(0, 9);
		if (down && cur_level < 1023) begin
			if (pick == 0)
				return SAMPLE_BITS'(cur_level + 1);
			if (pick == 1)
				return '1;
			return SAMPLE_BITS'($urandom_range(cur_level + 1, 1023));
		end
		if (pick == 0)
			return SAMPLE_BITS'(cur_level);
		if (pick == 1)
			return '0;
		return SAMPLE_BITS'($urandom_range(0, cur_level));
	endfunction

	// Scan of one row following the held keys, with some noisy readings
	function automatic in_req_t scan_request(input int row, input int toggle_pct);
		int s [COL_COUNT];
		int btn;
		for (int c = 0; c < COL_COUNT; c++) begin
			btn = c * ROW_COUNT + row;
			if ($urandom_range(0, 99) < toggle_pct)
				held_down[btn] = !held_down[btn];
			if ($urandom_range(0, 99) < 12)
				s[c] = $urandom_range(0, 1023);
			else
				s[c] = analog_reading(held_down[btn]);
		end
		return scan_of(row, s[0], s[1], s[2], s[3]);
	endfunction

	task automatic random_request(input int tick_pct, input int toggle_pct);
		if ($urandom_range(0, 99) < tick_pct)
			send_request(tick_request());
		else
			send_request(scan_request($urandom_range(0, ROW_COUNT - 1), toggle_pct));
	endtask

	// Event-port stalls: changing patterns, plus long hold-offs on request
	initial begin : receiver
		rx_mode_t mode;
		int       mode_left;
		int       hold_left;
		int       hold_off_seen;
		mode          = RX_OPEN;
		mode_left     = 0;
		hold_left     = 0;
		hold_off_seen = 0;
		out_ready     = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off_asked != hold_off_seen) begin
				hold_off_seen = hold_off_asked;
				hold_left     = HOLD_OFF_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				if (mode_left == 0) begin
					mode      = rx_mode_t'($urandom_range(0, 3));
					mode_left = $urandom_range(16, 96);
				end
				mode_left--;
				case (mode)
				RX_OPEN:  out_ready <= 1'b1;
				RX_LIGHT: out_ready <= ($urandom_range(0, 3) != 0);
				RX_HEAVY: out_ready <= ($urandom_range(0, 9) < 4);
				default:  out_ready <= ~out_ready;
				endcase
			end
		end
	end

	// End the run if it hangs
	initial begin : watchdog
		cycle_count = 0;
		while (cycle_count < LIMIT_CYCLES) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin : stimulus
		int level;
		int hold;
		int tick_pct;
		int phase;
		int random_start;
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		in_data        = '0;
		cfg_we         = 1'b0;
		cfg_addr       = '0;
		cfg_wdata      = '0;
		hold_off_asked = 0;
		burst_left     = 0;
		requests_sent  = 0;
		cur_level      = int'(PRESS_LEVEL_RST);
		foreach (held_down[i])
			held_down[i] = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed: ignored tick fields, full-scale press, threshold edges,
		// release after the hold time
		send_request(scan_of(0, 0, 0, 0, 0) | {1'b1, {($bits(in_req_t) - 1){1'b1}}});
		send_request(scan_of(0, 1023, 1023, 1023, 1023));
		send_request(scan_of(0, 1023, 1023, 1023, 1023));
		send_request(scan_of(7, 200, 201, 0, 'h2AA));
		send_request(scan_of(0, 0, 0, 0, 0));
		repeat (11) send_request(tick_request());
		send_request(scan_of(0, 0, 0, 0, 0));
		send_request(scan_of(3, 'h155, 'h3FF, 0, 'h2AA));
		send_request(scan_of(7, 0, 0, 0, 0));

		// A hold of 255 never releases; a lower hold releases the same off time
		apply_setting(600, 255);
		send_request(scan_of(5, 1023, 1023, 1023, 601));
		send_request(scan_of(5, 600, 0, 0, 0));
		repeat (40) send_request(tick_request());
		send_request(scan_of(5, 0, 0, 0, 0));
		apply_setting(600, 30);
		send_request(scan_of(5, 0, 0, 0, 0));

		// Random phases, each under its own register setting
		phase        = 0;
		random_start = requests_sent;
		while (requests_sent - random_start < RANDOM_REQUESTS) begin
			case (phase % 6)
			0: begin level = 0;    hold = 0;   end
			1: begin level = 1023; hold = 254; end
			2: begin level = 512;  hold = 3;   end
			3: begin level = $urandom_range(1, 1022); hold = $urandom_range(0, 12); end
			4: begin level = 150;  hold = 1;   end
			default: begin
				level = $urandom_range(0, 1023);
				hold  = $urandom_range(0, 30);
			end
			endcase
			apply_setting(level, hold);
			tick_pct = (hold > 20) ? 60 : 35;
			if (phase == 2) begin
				// hold off the event port and keep pushing requests
				hold_off_asked <= hold_off_asked + 1;
				burst_left = 40;
				repeat (24) random_request(20, 50);
			end
			repeat ($urandom_range(24, 40)) begin
				random_request(tick_pct, 15);
				if ($urandom_range(0, 49) == 0)
					drain_events();
			end
			phase++;
		end

		drain_events();
		repeat (8) @(posedge clk);
		if (mismatch_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
